/* rtl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants for the great-circle distance pipeline
// Fixed-point constants, the CORDIC arctangent table and the format helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Angle reduction constants, degrees with 17 fraction bits.
  localparam logic signed [27:0] DEG360_Q17 = 28'sd47185920;
  localparam logic [25:0] DEG90_Q17  = 26'd11796480;
  localparam logic [25:0] DEG180_Q17 = 26'd23592960;
  localparam logic [25:0] DEG270_Q17 = 26'd35389440;

  // pi/180 in Q32, the inverse CORDIC gain in Q30, twice the radius in Q16.
  localparam logic [26:0] PI_OVER_180_Q32 = 27'd74961321;
  localparam longint GAIN_INV_Q30 = 64'sd652032874;
  localparam logic [28:0] RADIUS2_Q16 = 29'd451401286;

  // Half the circumference in 1/256 nautical mile.
  localparam logic [21:0] DIST_MAX = 22'd2769741;

  // atan(2^-i) in Q30.
  localparam longint ATAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1, 0
  };

  // Rounds a Q30 value to f fraction bits, half up.
  function automatic longint q30_to_f(input longint v, input int f);
    return (v + (longint'(1) << (29 - f))) >>> (30 - f);
  endfunction

  // Arctangent table entry i, rounded to f fraction bits.
  function automatic longint atan_f(input int i, input int f);
    return q30_to_f(ATAN_Q30[i & 31], f);
  endfunction

endpackage

/* rtl/gcd_sincos.sv */
// ----------------------------------------------------------------------------
// gcd_sincos: pipelined sine and cosine of an angle in degrees
// Reduces the angle to a quadrant and residue, converts it to radians and
// runs one rotation CORDIC iteration per register stage.
// ----------------------------------------------------------------------------
module gcd_sincos #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [25:0]           ang,
  output logic signed [ANGLE_FRAC_BITS+1:0] sin_out,
  output logic signed [ANGLE_FRAC_BITS+1:0] cos_out
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int N  = CORDIC_STAGES;
  localparam int W  = F + 3;
  localparam int SH = 49 - F;
  localparam logic signed [W-1:0] X0  = W'(gcd_pkg::q30_to_f(gcd_pkg::GAIN_INV_Q30, F));
  localparam logic signed [W-1:0] ONE = W'(longint'(1) << F);

  logic signed [27:0] ang_w;
  logic [25:0] m0;
  logic [1:0]  q1, q2;
  logic [23:0] r1;
  logic [50:0] p2;
  logic signed [W-1:0] z_in;
  logic signed [W-1:0] xs [N];
  logic signed [W-1:0] ys [N];
  logic signed [W-1:0] zs [N];
  logic [1:0]          qs [N];
  logic signed [F+1:0] xc, yc;

  function automatic logic signed [F+1:0] clamp1(input logic signed [W-1:0] v);
    if (v > ONE) return (F+2)'(ONE);
    if (v < -ONE) return (F+2)'(-ONE);
    return (F+2)'(v);
  endfunction

  assign ang_w = 28'(ang);

  // Angle modulo 360 degrees, then quadrant and residue, then radians.
  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= ang_w[27] ? 26'(ang_w + gcd_pkg::DEG360_Q17) : 26'(ang_w);
      if (m0 >= gcd_pkg::DEG270_Q17) begin
        q1 <= 2'd3;
        r1 <= 24'(m0 - gcd_pkg::DEG270_Q17);
      end else if (m0 >= gcd_pkg::DEG180_Q17) begin
        q1 <= 2'd2;
        r1 <= 24'(m0 - gcd_pkg::DEG180_Q17);
      end else if (m0 >= gcd_pkg::DEG90_Q17) begin
        q1 <= 2'd1;
        r1 <= 24'(m0 - gcd_pkg::DEG90_Q17);
      end else begin
        q1 <= 2'd0;
        r1 <= m0[23:0];
      end
      p2 <= 51'(r1) * 51'(gcd_pkg::PI_OVER_180_Q32);
      q2 <= q1;
    end
  end

  assign z_in = W'((52'(p2) + (52'd1 << (48 - F))) >> SH);

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [W-1:0] AT = W'(gcd_pkg::atan_f(i, F));
    logic signed [W-1:0] xi, yi, zi;
    logic [1:0] qi;
    if (i == 0) begin : g_first
      assign xi = X0;
      assign yi = '0;
      assign zi = z_in;
      assign qi = q2;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign qi = qs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - AT;
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + AT;
        end
        qs[i] <= qi;
      end
    end
  end

  assign xc = clamp1(xs[N-1]);
  assign yc = clamp1(ys[N-1]);

  // Quadrant mapping of the first-quadrant result.
  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[N-1])
        2'd0: begin
          cos_out <= xc;
          sin_out <= yc;
        end
        2'd1: begin
          cos_out <= -yc;
          sin_out <= xc;
        end
        2'd2: begin
          cos_out <= -xc;
          sin_out <= -yc;
        end
        default: begin
          cos_out <= yc;
          sin_out <= -xc;
        end
      endcase
    end
  end

endmodule

/* rtl/great_circle_distance.sv */
// ----------------------------------------------------------------------------
// great_circle_distance: pipelined haversine distance between two positions
// Sine and cosine, square roots and atan2 run as fixed-length CORDIC and
// digit-by-digit stages; the result is in 1/256 nautical mile, saturated.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Beat contents
//  s_*      input      s_tvalid / s_tready  lat_a, lon_a, lat_b, lon_b
//  m_*      output     m_tvalid / m_tready  distance
//
// One beat is accepted per clock cycle when the output is not stalled.
// The pipeline holds the rotation CORDIC, the square-root digit stages
// and the vectoring CORDIC, one register stage per iteration or digit,
// besides the angle reduction, haversine and distance registers.
// Reset (rst, synchronous) clears only the per-stage valid bits.
// A stall at the output freezes every stage at once; nothing is lost.
//
module great_circle_distance #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // lat_a [23:0], lon_a [48:24], lat_b [72:49], lon_b [97:73], zero pad
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // distance [21:0], zero pad
  output logic [23:0]  m_tdata
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int W   = F + 3;          // CORDIC datapath width
  localparam int RW  = 2 * F + 3;      // square-root remainder width
  localparam int MW  = F + 2 + 29;     // distance product width
  localparam int LAT = 2 * N + F + 11;
  localparam logic signed [F+2:0] ONE_S = (F+3)'(longint'(1) << F);
  localparam logic [F:0] ONE_U = (F+1)'(longint'(1) << F);
  localparam logic signed [2*F+3:0] HALF_P = (2*F+4)'(longint'(1) << (F - 1));

  // The whole pipeline advances together whenever the output can move.
  logic en;
  logic [LAT-1:0] vld;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Rounded fixed-point product; both operands lie within [-1, 1].
  function automatic logic signed [F+1:0] mulf(input logic signed [F+1:0] a,
                                                input logic signed [F+1:0] b);
    logic signed [2*F+3:0] p;
    p = (2*F+4)'(a) * (2*F+4)'(b);
    p = p + HALF_P;
    return (F+2)'(p >>> F);
  endfunction

  // Half differences: a Q16 difference read as Q17 degrees is exactly half,
  // and a Q16 latitude doubled is the same latitude in Q17.
  logic signed [23:0] lat_a, lat_b;
  logic signed [24:0] lon_a, lon_b;
  logic signed [25:0] d_lat, d_lon, t_a, t_b;

  assign lat_a = s_tdata[23:0];
  assign lon_a = s_tdata[48:24];
  assign lat_b = s_tdata[72:49];
  assign lon_b = s_tdata[97:73];

  always_ff @(posedge clk) begin
    if (en) begin
      d_lat <= 26'(lat_b) - 26'(lat_a);
      d_lon <= 26'(lon_b) - 26'(lon_a);
      t_a   <= 26'(lat_a) <<< 1;
      t_b   <= 26'(lat_b) <<< 1;
    end
  end

  logic signed [F+1:0] s_lat, s_lon, c_a, c_b;

  gcd_sincos #(.CORDIC_STAGES(N), .ANGLE_FRAC_BITS(F)) u_sc_lat (
    .clk(clk), .en(en), .ang(d_lat), .sin_out(s_lat), .cos_out()
  );
  gcd_sincos #(.CORDIC_STAGES(N), .ANGLE_FRAC_BITS(F)) u_sc_lon (
    .clk(clk), .en(en), .ang(d_lon), .sin_out(s_lon), .cos_out()
  );
  gcd_sincos #(.CORDIC_STAGES(N), .ANGLE_FRAC_BITS(F)) u_sc_a (
    .clk(clk), .en(en), .ang(t_a), .sin_out(), .cos_out(c_a)
  );
  gcd_sincos #(.CORDIC_STAGES(N), .ANGLE_FRAC_BITS(F)) u_sc_b (
    .clk(clk), .en(en), .ang(t_b), .sin_out(), .cos_out(c_b)
  );

  // The haversine term a, over three stages of products and a clamped sum.
  logic signed [F+1:0] sl2, cc, so2, sl2b, t2;
  logic signed [F+2:0] a_sum;
  logic [F:0] a3;

  assign a_sum = (F+3)'(sl2b) + (F+3)'(t2);

  always_ff @(posedge clk) begin
    if (en) begin
      sl2  <= mulf(s_lat, s_lat);
      cc   <= mulf(c_a, c_b);
      so2  <= mulf(s_lon, s_lon);
      sl2b <= sl2;
      t2   <= mulf(cc, so2);
      if (a_sum < 0) begin
        a3 <= '0;
      end else if (a_sum > ONE_S) begin
        a3 <= ONE_U;
      end else begin
        a3 <= (F+1)'(a_sum);
      end
    end
  end

  // Floor square roots of a and 1 - a in QF, one result bit per stage from
  // the top. The remainder holds n - root^2.
  logic [RW-1:0] rem_u [F+1];
  logic [RW-1:0] rem_v [F+1];
  logic [RW-1:0] res_u [F+1];
  logic [RW-1:0] res_v [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    localparam int K = F - j;
    logic [RW-1:0] ru, rv, qu, qv, tu, tv;
    if (j == 0) begin : g_first
      assign ru = RW'(a3) << F;
      assign rv = RW'(ONE_U - a3) << F;
      assign qu = '0;
      assign qv = '0;
    end else begin : g_next
      assign ru = rem_u[j-1];
      assign rv = rem_v[j-1];
      assign qu = res_u[j-1];
      assign qv = res_v[j-1];
    end
    assign tu = (qu << (K + 1)) + (RW'(1) << (2 * K));
    assign tv = (qv << (K + 1)) + (RW'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if (ru >= tu) begin
          rem_u[j] <= ru - tu;
          res_u[j] <= qu + (RW'(1) << K);
        end else begin
          rem_u[j] <= ru;
          res_u[j] <= qu;
        end
        if (rv >= tv) begin
          rem_v[j] <= rv - tv;
          res_v[j] <= qv + (RW'(1) << K);
        end else begin
          rem_v[j] <= rv;
          res_v[j] <= qv;
        end
      end
    end
  end

  // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)); a zero numerator
  // forces a zero angle, so coincident points give zero distance.
  logic signed [W-1:0] vx [N];
  logic signed [W-1:0] vy [N];
  logic signed [W-1:0] vz [N];
  logic                vzero [N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [W-1:0] AT = W'(gcd_pkg::atan_f(i, F));
    logic signed [W-1:0] xi, yi, zi;
    logic zf;
    if (i == 0) begin : g_first
      assign xi = W'(res_v[F]);
      assign yi = W'(res_u[F]);
      assign zi = '0;
      assign zf = (res_u[F] == '0);
    end else begin : g_next
      assign xi = vx[i-1];
      assign yi = vy[i-1];
      assign zi = vz[i-1];
      assign zf = vzero[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          vx[i] <= xi + (yi >>> i);
          vy[i] <= yi - (xi >>> i);
          vz[i] <= zi + AT;
        end else begin
          vx[i] <= xi - (yi >>> i);
          vy[i] <= yi + (xi >>> i);
          vz[i] <= zi - AT;
        end
        vzero[i] <= zf;
      end
    end
  end

  // Distance: 2 z R rounded to 1/256 nautical mile, then saturated.
  logic [F+1:0] z_pos;
  logic [MW-1:0] prod;
  logic [MW-1:0] d_full;
  logic [21:0] distance;

  assign z_pos  = (vzero[N-1] || vz[N-1] < 0) ? '0 : (F+2)'(vz[N-1]);
  assign d_full = (prod + (MW'(1) << (F + 7))) >> (F + 8);

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= MW'(z_pos) * MW'(gcd_pkg::RADIUS2_Q16);
      distance <= (d_full > MW'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : 22'(d_full);
    end
  end

  assign m_tdata = {2'b00, distance};

  // The result never exceeds half the circumference.
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:0] <= gcd_pkg::DIST_MAX))
    else $error("distance above saturation limit");

  // A stalled output freezes every valid bit in the pipeline.
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && !rst) |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // A beat taken at the input shows up in the first stage.
  a_first_stage: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted beat missing from the first stage");

endmodule
